/* hdl/ctv_pkg.sv */
package ctv_pkg;

    localparam int REM_DIGIT = 4;
    localparam int REM_STEPS = 64 / REM_DIGIT;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_ENTRY  = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;

    localparam logic [2:0] STS_OK          = 3'd0;
    localparam logic [2:0] STS_EARLY_TERM  = 3'd1;
    localparam logic [2:0] STS_MISALIGNED  = 3'd2;
    localparam logic [2:0] STS_BAD_OFFSETS = 3'd3;
    localparam logic [2:0] STS_DUPLICATE   = 3'd4;
    localparam logic [2:0] STS_FINAL_ID    = 3'd5;
    localparam logic [2:0] STS_NOT_FOUND   = 3'd6;
    localparam logic [2:0] STS_REJECTED    = 3'd7;

    localparam logic [1:0] CFG_FILE_SIZE = 2'd0;
    localparam logic [1:0] CFG_HASH_LEN  = 2'd1;
    localparam logic [1:0] CFG_ALIGNMENT = 2'd2;

    typedef enum logic [1:0] {
        PH_LOADING,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] entry_id;
        logic [63:0] entry_offset;
        logic        is_last;
        logic [31:0] lookup_id;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] found_offset;
        logic [63:0] found_size;
        logic [4:0]  entries_count;
    } out_t;

    // search result handed from cell to cell
    typedef struct packed {
        logic        hit;
        logic [63:0] offset;
        logic [63:0] size;
    } res_t;

    // broadcast to every cell
    typedef struct packed {
        logic        commit;
        logic [31:0] key;
        logic [31:0] wr_id;
        logic [63:0] wr_offset;
        logic [63:0] wr_size;
    } cell_ctrl_t;

endpackage

/* hdl/ctv_cell.sv */
module ctv_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                clk,
    input  ctv_pkg::cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]    count,
    input  ctv_pkg::res_t       prev,
    output ctv_pkg::res_t       res
);

    logic [31:0]   id_reg;
    logic [63:0]   offset_reg;
    logic [63:0]   size_reg;
    ctv_pkg::res_t res_reg;
    ctv_pkg::res_t res_next;
    logic          match;

    // only slots below the fill count hold live entries
    assign match = (CNT_W'(IDX) < count) && (id_reg == ctrl.key);

    always_comb
    begin
        if (match)
        begin
            res_next.hit    = 1'b1;
            res_next.offset = offset_reg;
            res_next.size   = size_reg;
        end
        else
        begin
            res_next = prev;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (ctrl.commit && (count == CNT_W'(IDX)))
        begin
            id_reg     <= ctrl.wr_id;
            offset_reg <= ctrl.wr_offset;
            size_reg   <= ctrl.wr_size;
        end
    end

    assign res = res_reg;

endmodule

/* hdl/ctv_rem.sv */
module ctv_rem (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [12:0] divisor,
    output logic [12:0] rem
);

    localparam int STEP_W = $clog2(ctv_pkg::REM_STEPS + 1);

    logic [63:0]     div_reg;
    logic [63:0]     div_next;
    logic [12:0]     rem_reg;
    logic [12:0]     rem_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    // four restoring steps per cycle, MSB first
    always_comb
    begin
        logic [13:0] r;
        r         = {1'b0, rem_reg};
        div_next  = div_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        if (start)
        begin
            div_next  = dividend;
            rem_next  = '0;
            step_next = '0;
        end
        else if (step_reg < STEP_W'(ctv_pkg::REM_STEPS))
        begin
            for (int j = 0; j < ctv_pkg::REM_DIGIT; j++)
            begin
                r = {r[12:0], div_reg[63-j]};
                if (r >= {1'b0, divisor})
                begin
                    r = r - {1'b0, divisor};
                end
            end
            rem_next  = r[12:0];
            div_next  = div_reg << ctv_pkg::REM_DIGIT;
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_W'(ctv_pkg::REM_STEPS);
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign rem = rem_reg;

endmodule

/* hdl/chunk_toc_validator_unit.sv */
// Chunk table-of-contents validator.
// Requests arrive on in_valid/in_ready/in_data: func 0 clears the table,
// func 1 feeds one table entry (the terminator carries is_last), func 2
// looks an id up once the load has completed. Every request yields exactly
// one response on out_valid/out_ready/out_data.
// The table lives in a row of MAX_CHUNKS cells. For entries and lookups
// the search id is broadcast to all cells; each cell compares it with its
// own id and the hit travels one cell per cycle down the row to the last
// cell. The offset alignment test runs alongside in a radix-16 remainder
// unit. Entries during a load and lookups after it pass through the run
// state before the response is offered; clear, rejected and unknown
// requests go straight to the output state. One request is in flight at
// a time; in_ready returns the cycle after the response is taken.
// A stalled receiver holds the response in the output register and
// in_ready stays low until it is taken.
// Reset empties the table, drops the pending entry, restarts the load and
// restores file_size 0, hash_len 20, alignment 4. Configuration writes on
// cfg_we/cfg_index/cfg_data apply at once and are meant for idle periods.
module chunk_toc_validator_unit #(
    parameter int MAX_CHUNKS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ctv_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ctv_pkg::out_t  out_data,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [63:0]    cfg_data
);

    localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
    localparam int RUN_LEN = (MAX_CHUNKS > ctv_pkg::REM_STEPS) ? MAX_CHUNKS
                                                               : ctv_pkg::REM_STEPS;
    localparam int RUN_W   = $clog2(RUN_LEN + 1);

    // configuration
    logic [63:0] file_size_reg;
    logic [6:0]  hash_len_reg;
    logic [12:0] alignment_reg;
    logic [12:0] align_eff;

    // control
    ctv_pkg::state_t state_reg, state_next;
    ctv_pkg::phase_t phase_reg, phase_next;
    logic [RUN_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pend_valid_reg, pend_valid_next;

    // datapath
    logic [31:0]   pend_id_reg, pend_id_next;
    logic [63:0]   pend_off_reg, pend_off_next;
    ctv_pkg::in_t  req_reg, req_next;
    logic [31:0]   key_reg, key_next;
    logic          off_bad_reg, off_bad_next;
    logic [63:0]   size_reg, size_next;
    ctv_pkg::out_t out_reg, out_next;

    logic          accept;
    logic          needs_run;
    logic          finish;
    logic          commit;
    logic [12:0]   rem;
    ctv_pkg::cell_ctrl_t ctrl;
    ctv_pkg::res_t chain [MAX_CHUNKS+1];

    assign align_eff = (alignment_reg == '0) ? 13'd1 : alignment_reg;
    assign accept    = in_valid && in_ready;
    assign needs_run = ((in_data.func == ctv_pkg::FUNC_ENTRY)
                        && (phase_reg == ctv_pkg::PH_LOADING))
                    || ((in_data.func == ctv_pkg::FUNC_LOOKUP)
                        && (phase_reg == ctv_pkg::PH_DONE));
    assign finish    = (state_reg == ctv_pkg::S_RUN) && (cnt_reg == RUN_W'(RUN_LEN));

    // ---- next state ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ctv_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = needs_run ? ctv_pkg::S_RUN : ctv_pkg::S_OUT;
                end
            end
            ctv_pkg::S_RUN:
            begin
                if (finish)
                begin
                    state_next = ctv_pkg::S_OUT;
                end
            end
            ctv_pkg::S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ctv_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ctv_pkg::S_IDLE;
            end
        endcase
    end

    // ---- handshake outputs ----
    always_comb
    begin
        in_ready  = (state_reg == ctv_pkg::S_IDLE);
        out_valid = (state_reg == ctv_pkg::S_OUT);
    end

    // ---- datapath ----
    always_comb
    begin
        logic [2:0] sts;
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_off_next   = pend_off_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        out_next        = out_reg;
        commit          = 1'b0;
        sts             = ctv_pkg::STS_OK;
        // offset tests and chunk size, settled well before the finish cycle
        off_bad_next    = (file_size_reg < {57'd0, hash_len_reg})
                       || (req_reg.entry_offset < pend_off_reg)
                       || (req_reg.entry_offset > (file_size_reg - {57'd0, hash_len_reg}));
        size_next       = req_reg.entry_offset - pend_off_reg;

        if (state_reg == ctv_pkg::S_IDLE && accept)
        begin
            req_next = in_data;
            cnt_next = '0;
            key_next = (in_data.func == ctv_pkg::FUNC_ENTRY) ? pend_id_reg
                                                              : in_data.lookup_id;
            out_next.found_offset = '0;
            out_next.found_size   = '0;
            if (in_data.func == ctv_pkg::FUNC_CLEAR)
            begin
                count_next      = '0;
                pend_valid_next = 1'b0;
                pend_id_next    = '0;
                pend_off_next   = '0;
                phase_next      = ctv_pkg::PH_LOADING;
                out_next.status        = ctv_pkg::STS_OK;
                out_next.entries_count = '0;
            end
            else
            begin
                out_next.status        = ctv_pkg::STS_REJECTED;
                out_next.entries_count = 5'(count_reg);
            end
        end
        else if (state_reg == ctv_pkg::S_RUN)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (finish)
            begin
                out_next.found_offset  = '0;
                out_next.found_size    = '0;
                out_next.entries_count = 5'(count_reg);
                if (req_reg.func == ctv_pkg::FUNC_LOOKUP)
                begin
                    if (chain[MAX_CHUNKS].hit)
                    begin
                        out_next.status       = ctv_pkg::STS_OK;
                        out_next.found_offset = chain[MAX_CHUNKS].offset;
                        out_next.found_size   = chain[MAX_CHUNKS].size;
                    end
                    else
                    begin
                        out_next.status = ctv_pkg::STS_NOT_FOUND;
                    end
                end
                else
                begin
                    // close off the pending entry first
                    if (pend_valid_reg)
                    begin
                        if (off_bad_reg)
                        begin
                            sts = ctv_pkg::STS_BAD_OFFSETS;
                        end
                        else if (chain[MAX_CHUNKS].hit)
                        begin
                            sts = ctv_pkg::STS_DUPLICATE;
                        end
                        else if (count_reg >= CNT_W'(MAX_CHUNKS))
                        begin
                            sts = ctv_pkg::STS_REJECTED;
                        end
                        else
                        begin
                            commit          = 1'b1;
                            count_next      = count_reg + 1'b1;
                            pend_valid_next = 1'b0;
                            out_next.entries_count = 5'(count_reg + 1'b1);
                        end
                    end
                    // then check the new entry itself
                    if (sts == ctv_pkg::STS_OK)
                    begin
                        if (req_reg.is_last)
                        begin
                            sts = (req_reg.entry_id != '0) ? ctv_pkg::STS_FINAL_ID
                                                           : ctv_pkg::STS_OK;
                        end
                        else if (req_reg.entry_id == '0)
                        begin
                            sts = ctv_pkg::STS_EARLY_TERM;
                        end
                        else if (rem != '0)
                        begin
                            sts = ctv_pkg::STS_MISALIGNED;
                        end
                        else
                        begin
                            pend_valid_next = 1'b1;
                            pend_id_next    = req_reg.entry_id;
                            pend_off_next   = req_reg.entry_offset;
                        end
                    end
                    if (sts != ctv_pkg::STS_OK)
                    begin
                        pend_valid_next = 1'b0;
                        phase_next      = ctv_pkg::PH_ERROR;
                    end
                    else if (req_reg.is_last)
                    begin
                        phase_next = ctv_pkg::PH_DONE;
                    end
                    out_next.status = sts;
                end
            end
        end
    end

    // ---- registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ctv_pkg::S_IDLE;
            phase_reg      <= ctv_pkg::PH_LOADING;
            cnt_reg        <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_id_reg    <= '0;
            pend_off_reg   <= '0;
            file_size_reg  <= 64'd0;
            hash_len_reg   <= 7'd20;
            alignment_reg  <= 13'd4;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            pend_id_reg    <= pend_id_next;
            pend_off_reg   <= pend_off_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ctv_pkg::CFG_FILE_SIZE: file_size_reg <= cfg_data;
                    ctv_pkg::CFG_HASH_LEN:  hash_len_reg  <= cfg_data[6:0];
                    ctv_pkg::CFG_ALIGNMENT: alignment_reg <= cfg_data[12:0];
                    default:                ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        key_reg     <= key_next;
        off_bad_reg <= off_bad_next;
        size_reg    <= size_next;
        out_reg     <= out_next;
    end

    assign out_data = out_reg;

    // ---- alignment remainder ----
    ctv_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && needs_run),
        .dividend (in_data.entry_offset),
        .divisor  (align_eff),
        .rem      (rem)
    );

    // ---- row of table cells ----
    assign ctrl.commit    = commit;
    assign ctrl.key       = key_reg;
    assign ctrl.wr_id     = pend_id_reg;
    assign ctrl.wr_offset = pend_off_reg;
    assign ctrl.wr_size   = size_reg;

    assign chain[0] = '0;

    for (genvar i = 0; i < MAX_CHUNKS; i++)
    begin : g_cell
        ctv_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .count (count_reg),
            .prev  (chain[i]),
            .res   (chain[i+1])
        );
    end

endmodule
